// File: design/jsu_pkg.sv
// Shared types, codes and helper functions of the JSON string unescape decoder.
package jsu_pkg;

  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_ESCAPE = 3'd1;
  localparam logic [2:0] ERR_HEX    = 3'd2;
  localparam logic [2:0] ERR_TRUNC  = 3'd3;
  localparam logic [2:0] ERR_UNTERM = 3'd4;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_HEX3   = 3'd4,
    MODE_HEX4   = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic [2:0] error_code;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                       cnt;
    out_item_t [MAX_RESULTS-1:0]      res;
  } dec_t;

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  function automatic out_item_t mk_result(input logic [7:0] b, input logic [1:0] st,
                                          input logic [2:0] err, input logic lst);
    out_item_t r;
    r.out_byte   = b;
    r.status     = st;
    r.error_code = err;
    r.last       = lst;
    return r;
  endfunction

endpackage

// File: design/jsu_decode.sv
// Escape decoder: mode and hex registers and the per-byte result generation.
module jsu_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  jsu_pkg::in_item_t item,
  output jsu_pkg::dec_t   dec
);
  import jsu_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [4:0]  hv;
  logic [15:0] code;

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    dec      = '0;
    hv       = hex_value(item.in_byte);
    code     = {acc_r, hv[3:0]};
    if (code >= 16'hD800 && code <= 16'hDFFF) begin
      code = 16'hFFFD;
    end
    if (item.end_of_text) begin
      mode_nxt = MODE_NORMAL;
      acc_nxt  = '0;
      dec.cnt  = 2'd1;
      if (mode_r == MODE_HEX1 || mode_r == MODE_HEX2 || mode_r == MODE_HEX3 ||
          mode_r == MODE_HEX4) begin
        dec.res[0] = mk_result(8'd0, ST_ERROR, ERR_TRUNC, 1'b1);
      end else begin
        dec.res[0] = mk_result(8'd0, ST_ERROR, ERR_UNTERM, 1'b1);
      end
    end else begin
      case (mode_r)
        MODE_ESCAPE: begin
          mode_nxt = MODE_NORMAL;
          dec.cnt  = 2'd1;
          case (item.in_byte)
            CH_QUOTE:     dec.res[0] = mk_result(CH_QUOTE, ST_BYTE, ERR_NONE, 1'b1);
            CH_BACKSLASH: dec.res[0] = mk_result(CH_BACKSLASH, ST_BYTE, ERR_NONE, 1'b1);
            CH_SLASH:     dec.res[0] = mk_result(CH_SLASH, ST_BYTE, ERR_NONE, 1'b1);
            CH_B:         dec.res[0] = mk_result(8'h08, ST_BYTE, ERR_NONE, 1'b1);
            CH_F:         dec.res[0] = mk_result(8'h0C, ST_BYTE, ERR_NONE, 1'b1);
            CH_N:         dec.res[0] = mk_result(8'h0A, ST_BYTE, ERR_NONE, 1'b1);
            CH_R:         dec.res[0] = mk_result(8'h0D, ST_BYTE, ERR_NONE, 1'b1);
            CH_T:         dec.res[0] = mk_result(8'h09, ST_BYTE, ERR_NONE, 1'b1);
            CH_U: begin
              mode_nxt = MODE_HEX1;
              acc_nxt  = '0;
              dec.cnt  = 2'd0;
            end
            default: begin
              acc_nxt    = '0;
              dec.res[0] = mk_result(8'd0, ST_ERROR, ERR_ESCAPE, 1'b1);
            end
          endcase
        end
        MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
          if (!hv[4]) begin
            mode_nxt   = MODE_NORMAL;
            acc_nxt    = '0;
            dec.cnt    = 2'd1;
            dec.res[0] = mk_result(8'd0, ST_ERROR, ERR_HEX, 1'b1);
          end else if (mode_r != MODE_HEX4) begin
            mode_nxt = mode_t'(mode_r + 3'd1);
            acc_nxt  = {acc_r[7:0], hv[3:0]};
          end else begin
            mode_nxt = MODE_NORMAL;
            acc_nxt  = '0;
            if (code < 16'h0080) begin
              dec.cnt    = 2'd1;
              dec.res[0] = mk_result(code[7:0], ST_BYTE, ERR_NONE, 1'b1);
            end else if (code < 16'h0800) begin
              dec.cnt    = 2'd2;
              dec.res[0] = mk_result({3'b110, code[10:6]}, ST_BYTE, ERR_NONE, 1'b0);
              dec.res[1] = mk_result({2'b10, code[5:0]}, ST_BYTE, ERR_NONE, 1'b1);
            end else begin
              dec.cnt    = 2'd3;
              dec.res[0] = mk_result({4'b1110, code[15:12]}, ST_BYTE, ERR_NONE, 1'b0);
              dec.res[1] = mk_result({2'b10, code[11:6]}, ST_BYTE, ERR_NONE, 1'b0);
              dec.res[2] = mk_result({2'b10, code[5:0]}, ST_BYTE, ERR_NONE, 1'b1);
            end
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
          if (item.in_byte == CH_QUOTE) begin
            acc_nxt    = '0;
            dec.cnt    = 2'd1;
            dec.res[0] = mk_result(8'd0, ST_DONE, ERR_NONE, 1'b1);
          end else if (item.in_byte == CH_BACKSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            dec.cnt    = 2'd1;
            dec.res[0] = mk_result(item.in_byte, ST_BYTE, ERR_NONE, 1'b1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// File: design/jsu_result_fifo.sv
// Result buffer taking up to three results a cycle and releasing one a cycle while out_stall is low.
module jsu_result_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jsu_pkg::dec_t      push_dec,
  output logic               space_ok,
  output logic               out_valid,
  input  logic               out_stall,
  output jsu_pkg::out_item_t out_data
);
  import jsu_pkg::*;

  out_item_t          ent_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic [FIFO_CW-1:0] push_amt;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = ent_r[rd_r];
  assign pop       = out_valid && !out_stall;
  assign space_ok  = (cnt_r <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS));
  assign push_amt  = push ? FIFO_CW'(push_dec.cnt) : '0;

  always_comb begin
    wr_nxt  = wr_r + FIFO_AW'(push_amt);
    rd_nxt  = pop ? rd_r + FIFO_AW'(1) : rd_r;
    cnt_nxt = cnt_r + push_amt - (pop ? FIFO_CW'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (push && (i < int'(push_dec.cnt))) begin
        ent_r[wr_r + FIFO_AW'(i)] <= push_dec.res[i];
      end
    end
  end

endmodule

// File: design/json_string_unescape_decoder.sv
// JSON string unescape decoder top level: input register, decoder and result buffer.
// The block takes one byte of a JSON string body per cycle while in_stall is low and
// delivers one result per cycle while out_stall is low, via the input register, decoder
// and result buffer. Plain bytes, simple escapes, a closing quote and errors give one
// result each; a \uXXXX escape gives one to three UTF-8 bytes on its fourth digit.
// Decoding waits while the four-entry result buffer holds more than one result, so after
// a three-byte code point the input stalls until the single result port drains the buffer to one result.
module json_string_unescape_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jsu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jsu_pkg::out_item_t out_data
);
  import jsu_pkg::*;

  logic     inr_vld_r, inr_vld_nxt;
  in_item_t inr_data_r;
  logic     space_ok;
  logic     fire;
  logic     accept;
  dec_t     dec;

  assign fire     = inr_vld_r && space_ok;
  assign in_stall = inr_vld_r && !fire;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    inr_vld_nxt = inr_vld_r;
    if (accept) begin
      inr_vld_nxt = 1'b1;
    end else if (fire) begin
      inr_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inr_vld_r <= 1'b0;
    end else begin
      inr_vld_r <= inr_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inr_data_r <= in_data;
    end
  end

  jsu_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (inr_data_r),
    .dec   (dec)
  );

  jsu_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_dec  (dec),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: design/jsu_checker.sv
// Port-level checks of the JSON string unescape decoder and their binding.
module jsu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input jsu_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input jsu_pkg::out_item_t out_data
);
  import jsu_pkg::*;

  logic unused_in;
  assign unused_in = in_valid ^ in_stall ^ (^in_data);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.status == ST_ERROR) == (out_data.error_code != ERR_NONE)))
    else $error("error code does not match status");

  a_ctrl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_BYTE) |-> out_data.last && (out_data.out_byte == 8'd0))
    else $error("done or error result not final or carries a byte");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_BYTE || out_data.status == ST_DONE ||
                   out_data.status == ST_ERROR))
    else $error("unknown status");

endmodule

bind json_string_unescape_decoder jsu_checker u_jsu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
